FILE: design/stfh_pkg.sv
// Shared types, constants and helper functions for the split texture FNV hasher.
package stfh_pkg;

	// FNV-1a 64 constants.
	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

	// Default number of samples per section, and extra folds when rgb averages are used.
	localparam int SAMPLES_DEF = 121;
	localparam int RGB_EXTRA   = 3;

	// Saturation limits of the section accumulators.
	localparam logic [14:0] SUM_MAX   = 15'h7FFF;
	localparam logic [6:0]  COUNT_MAX = 7'd127;

	// Rounded average divider: one quotient bit per cycle over a 17-bit dividend.
	localparam int DVD_W     = 17;
	localparam int DIV_STEPS = DVD_W;

	// Scaling multiply: 64 x 16 bits per cycle.
	localparam int SLICE_W     = 16;
	localparam int SCALE_STEPS = 64 / SLICE_W;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One classified sample as it travels through the queue.
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       inside_req;
		logic       section_end;
		logic       tall;
	} item_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// One FNV-1a step; the prime is 2^40 + 0x1B3, so the multiply is a sum of shifts.
	function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] v);
		logic [63:0] x;
		x = h ^ {56'd0, v};
		return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	endfunction

	// Power of the FNV prime, evaluated at elaboration only.
	function automatic logic [63:0] prime_pow(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * FNV_PRIME;
		end
		return p;
	endfunction

endpackage

FILE: design/stfh_pix_if.sv
// Handshake interface carrying one sampled pixel per beat.
interface stfh_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       inside_req;
	logic       section_end;
	logic       tall;

	modport source(output valid, red, green, blue, inside_req, section_end, tall, input ready);
	modport sink(input valid, red, green, blue, inside_req, section_end, tall, output ready);
endinterface

FILE: design/stfh_hash_if.sv
// Handshake interface carrying one set of texture hashes per beat.
interface stfh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] combined_hash;
	logic [63:0] upper_hash;
	logic [63:0] lower_hash;

	modport source(output valid, combined_hash, upper_hash, lower_hash, input ready);
	modport sink(input valid, combined_hash, upper_hash, lower_hash, output ready);
endinterface

FILE: design/split_texture_fnv_hash.sv
// An ordinary pixel passes through the sequencer's pop and fold states after entering the queue.
// A section end adds, with averages on, the divider load, the divide and three average folds,
// plus scaling at a tall upper end. A new pixel is popped only once the last is folded.
// A 4-entry queue lets pixels enter while the sequencer divides, scales or waits on a result.
// Reset clears all hash state to the FNV offset basis and zeros, and sets use_rgb.
// The result register lets the next texture proceed while a finished result waits.
module split_texture_fnv_hash #(
	parameter int SAMPLES = stfh_pkg::SAMPLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	stfh_pix_if.sink     pixel,
	stfh_hash_if.source  result
);
	import stfh_pkg::*;

	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   pop_item;
	q_stat_t stat;

	// Accept and classify pixels.
	stfh_front u_front (
		.pixel     (pixel),
		.stat      (stat),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	stfh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (stat)
	);

	// Hashing sequencer.
	stfh_back #(
		.SAMPLES (SAMPLES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.pop_item    (pop_item),
		.pop         (pop),
		.result      (result)
	);
endmodule

FILE: design/stfh_queue.sv
// Small FIFO that decouples the sample front end from the hashing sequencer.
module stfh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stfh_pkg::item_t push_item,
	input  logic            pop,
	output stfh_pkg::item_t pop_item,
	output stfh_pkg::q_stat_t stat
);
	import stfh_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign pop_item   = mem_q[rd_ptr_q];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == (QPTR_W+1)'(QDEPTH));
endmodule

FILE: design/stfh_front.sv
// Front end: accepts sampled pixels, works out the sample value and pushes them to the queue.
module stfh_front (
	stfh_pix_if.sink          pixel,
	input  stfh_pkg::q_stat_t stat,
	output logic              push,
	output stfh_pkg::item_t   push_item
);
	import stfh_pkg::*;

	logic [9:0]  chan_sum;
	logic [19:0] third_prod;

	// floor(sum / 3) as a multiply by 683 / 2048, exact for sums up to 765.
	always_comb begin
		chan_sum   = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
		third_prod = {10'd0, chan_sum} * 20'd683;
	end

	// Pack the classified sample.
	always_comb begin
		push_item.value       = pixel.inside_req ? third_prod[18:11] : 8'd0;
		push_item.red         = pixel.red;
		push_item.green       = pixel.green;
		push_item.blue        = pixel.blue;
		push_item.inside_req  = pixel.inside_req;
		push_item.section_end = pixel.section_end;
		push_item.tall        = pixel.tall;
	end

	assign pixel.ready = !stat.full;
	assign push        = pixel.valid && !stat.full;
endmodule

FILE: design/stfh_back.sv
// Back end: sequencer that folds samples, divides channel averages, scales and emits hashes.
module stfh_back #(
	parameter int SAMPLES = stfh_pkg::SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  stfh_pkg::q_stat_t stat,
	input  stfh_pkg::item_t   pop_item,
	output logic              pop,
	stfh_hash_if.source       result
);
	import stfh_pkg::*;

	localparam logic [63:0] FACT_PLAIN = prime_pow(SAMPLES);
	localparam logic [63:0] FACT_RGB   = prime_pow(SAMPLES + RGB_EXTRA);
	localparam logic [63:0] SEED_PLAIN = FNV_BASIS * FACT_PLAIN;
	localparam logic [63:0] SEED_RGB   = FNV_BASIS * FACT_RGB;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FOLD   = 3'd1;
	localparam logic [2:0] ST_DLOAD  = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_AVG    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;
	localparam logic [2:0] ST_SCALE  = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	logic [2:0]  state_q;
	logic [4:0]  step_q;
	item_t       item_q;
	logic [63:0] run_q;
	logic [63:0] bot_q;
	logic [63:0] held_q;
	logic [63:0] acc_q;
	logic [14:0] rsum_q;
	logic [14:0] gsum_q;
	logic [14:0] bsum_q;
	logic [6:0]  cnt_q;
	logic        lower_q;
	logic        use_rgb_q;
	logic        out_vld_q;
	logic [63:0] out_comb_q;
	logic [63:0] out_upper_q;
	logic [63:0] out_lower_q;

	// Divider lanes: red, green, blue.
	logic [DVD_W-1:0] dvd_q [3];
	logic [7:0]       rem_q [3];
	logic [7:0]       quo_q [3];
	logic [7:0]       dvs_q;

	logic [DVD_W-1:0] dvd_d [3];
	logic [7:0]       rem_d [3];
	logic [7:0]       quo_d [3];
	logic [8:0]       shifted;

	logic [15:0] rsum_add;
	logic [15:0] gsum_add;
	logic [15:0] bsum_add;
	logic        take_rgb;
	logic [7:0]  avg_val;
	logic [63:0] fact;
	logic [63:0] seed;
	logic [79:0] scale_prod;
	logic [63:0] scale_part;
	logic        emit_go;

	assign pop      = (state_q == ST_IDLE) && !stat.empty;
	assign emit_go  = (state_q == ST_EMIT) && (!out_vld_q || result.ready);
	assign take_rgb = use_rgb_q && item_q.inside_req;
	assign fact     = use_rgb_q ? FACT_RGB : FACT_PLAIN;
	assign seed     = use_rgb_q ? SEED_RGB : SEED_PLAIN;
	assign avg_val  = quo_q[step_q[1:0]];

	// Saturating channel sums.
	always_comb begin
		rsum_add = {1'b0, rsum_q} + {8'd0, item_q.red};
		gsum_add = {1'b0, gsum_q} + {8'd0, item_q.green};
		bsum_add = {1'b0, bsum_q} + {8'd0, item_q.blue};
	end

	// One restoring division step per lane.
	always_comb begin
		shifted = '0;
		for (int i = 0; i < 3; i++) begin
			shifted  = {rem_q[i], dvd_q[i][DVD_W-1]};
			dvd_d[i] = {dvd_q[i][DVD_W-2:0], 1'b0};
			if (shifted >= {1'b0, dvs_q}) begin
				rem_d[i] = 8'(shifted - {1'b0, dvs_q});
				quo_d[i] = {quo_q[i][6:0], 1'b1};
			end else begin
				rem_d[i] = shifted[7:0];
				quo_d[i] = {quo_q[i][6:0], 1'b0};
			end
		end
	end

	// One 64 x 16 partial product of the blank-lower scaling.
	always_comb begin
		scale_prod = run_q * fact[step_q[1:0]*SLICE_W +: SLICE_W];
		scale_part = scale_prod[63:0] << (step_q[1:0] * SLICE_W);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_rgb_q <= 1'b1;
		end else if (cfg_wr_en) begin
			use_rgb_q <= cfg_wr_data;
		end
	end

	// Payload registers: popped sample, divider lanes, scaling accumulator.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_item;
		end
		if (state_q == ST_DLOAD) begin
			dvd_q[0] <= {1'b0, rsum_q, 1'b0} + {10'd0, cnt_q};
			dvd_q[1] <= {1'b0, gsum_q, 1'b0} + {10'd0, cnt_q};
			dvd_q[2] <= {1'b0, bsum_q, 1'b0} + {10'd0, cnt_q};
			dvs_q    <= {cnt_q, 1'b0};
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				dvd_q[i] <= dvd_d[i];
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
			end
		end
		if (state_q == ST_FINISH) begin
			acc_q <= '0;
		end else if (state_q == ST_SCALE) begin
			acc_q <= acc_q + scale_part;
		end
		if (emit_go) begin
			out_comb_q  <= run_q;
			out_upper_q <= lower_q ? held_q : run_q;
			out_lower_q <= lower_q ? bot_q : 64'd0;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Sequencer and hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			run_q   <= FNV_BASIS;
			bot_q   <= '0;
			held_q  <= '0;
			rsum_q  <= '0;
			gsum_q  <= '0;
			bsum_q  <= '0;
			cnt_q   <= '0;
			lower_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					run_q <= fnv_fold(run_q, item_q.value);
					if (lower_q) begin
						bot_q <= fnv_fold(bot_q, item_q.value);
					end
					if (take_rgb) begin
						rsum_q <= rsum_add[15] ? SUM_MAX : rsum_add[14:0];
						gsum_q <= gsum_add[15] ? SUM_MAX : gsum_add[14:0];
						bsum_q <= bsum_add[15] ? SUM_MAX : bsum_add[14:0];
					end
					if (cnt_q != COUNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!item_q.section_end) begin
						state_q <= ST_IDLE;
					end else if (use_rgb_q) begin
						state_q <= ST_DLOAD;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DLOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 5'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_AVG;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_AVG: begin
					// Red, then green, then blue average.
					run_q <= fnv_fold(run_q, avg_val);
					if (lower_q) begin
						bot_q <= fnv_fold(bot_q, avg_val);
					end
					if (step_q == 5'd2) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					step_q <= '0;
					if (!lower_q && item_q.tall) begin
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SCALE: begin
					if (step_q == 5'(SCALE_STEPS - 1)) begin
						// End of a tall upper section: start the lower one.
						held_q  <= acc_q + scale_part;
						bot_q   <= seed;
						lower_q <= 1'b1;
						rsum_q  <= '0;
						gsum_q  <= '0;
						bsum_q  <= '0;
						cnt_q   <= '0;
						step_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						run_q   <= FNV_BASIS;
						bot_q   <= '0;
						held_q  <= '0;
						rsum_q  <= '0;
						gsum_q  <= '0;
						bsum_q  <= '0;
						cnt_q   <= '0;
						lower_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_vld_q;
	assign result.combined_hash = out_comb_q;
	assign result.upper_hash    = out_upper_q;
	assign result.lower_hash    = out_lower_q;

	// After a result is loaded the texture state is back at its start values.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (run_q == FNV_BASIS) && !lower_q && (cnt_q == '0))
		else $error("texture state not cleared after emit");

	// The averaging divider never starts with a zero sample count.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DLOAD) |-> (cnt_q != '0))
		else $error("divider loaded with zero count");

	// Scaling happens only at the end of an upper section.
	a_scale_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> !lower_q)
		else $error("scaling inside lower section");

	// The lower hash stays zero while in the upper section.
	a_bot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!lower_q |-> (bot_q == '0) && (held_q == '0))
		else $error("lower hash touched in upper section");
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the split texture FNV hasher: directed textures, then random phases.
module testbench;
	import stfh_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int NUM_SAMPLES   = SAMPLES_DEF;
	localparam int PRINT_MAX     = 30;
	localparam int HOLD_OFF      = 300;
	localparam int PHASE_PIXELS  = 210;

	// One sampled pixel as the sender offers it.
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       inside_req;
		logic       section_end;
		logic       tall;
	} pixel_t;

	// The three hashes reported at the end of a texture.
	typedef struct {
		logic [63:0] combined;
		logic [63:0] upper;
		logic [63:0] lower;
	} texture_hashes_t;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic cfg_wr_en   = 1'b0;
	logic cfg_wr_data = 1'b0;

	stfh_pix_if  pix();
	stfh_hash_if res();

	split_texture_fnv_hash uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pixel       (pix),
		.result      (res)
	);

	// Shadow of the hasher state, kept up to date on every accepted pixel.
	logic [63:0] pred_running;
	logic [63:0] pred_lower;
	logic [63:0] pred_upper_held;
	int unsigned pred_red_sum;
	int unsigned pred_green_sum;
	int unsigned pred_blue_sum;
	int unsigned pred_count;
	bit          pred_in_lower;
	bit          pred_use_rgb;

	texture_hashes_t hash_expect_q[$];

	int errors          = 0;
	int pixels_sent     = 0;
	int results_checked = 0;
	int cycles          = 0;
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_cycles     = 0;

	always #CLK_HALF clk = ~clk;

	// One FNV-1a step over a 64-bit value.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [63:0] v);
		return (h ^ v) * FNV_PRIME;
	endfunction

	function automatic logic [63:0] prime_to(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * FNV_PRIME;
		end
		return p;
	endfunction

	// Channel average with halves rounded up; only the low byte is folded.
	function automatic logic [63:0] rounded_avg(input int unsigned sum, input int unsigned cnt);
		int unsigned q;
		q = (2 * sum + cnt) / (2 * cnt);
		return 64'(q & 32'hFF);
	endfunction

	function automatic int unsigned add_sat(input int unsigned s, input logic [7:0] v);
		int unsigned t;
		t = s + v;
		return (t > SUM_MAX) ? int'(SUM_MAX) : t;
	endfunction

	function automatic pixel_t px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic in_tex, input logic last, input logic tall);
		pixel_t p;
		p.red         = r;
		p.green       = g;
		p.blue        = b;
		p.inside_req  = in_tex;
		p.section_end = last;
		p.tall        = tall;
		return p;
	endfunction

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic int rand_section_len();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return $urandom_range(1, 4);
		end else if (r < 95) begin
			return $urandom_range(5, 30);
		end
		return $urandom_range(100, 131);
	endfunction

	task automatic predict_clear_section();
		pred_red_sum   = 0;
		pred_green_sum = 0;
		pred_blue_sum  = 0;
		pred_count     = 0;
	endtask

	task automatic predict_clear_texture();
		pred_running    = FNV_BASIS;
		pred_lower      = 64'd0;
		pred_upper_held = 64'd0;
		pred_in_lower   = 1'b0;
		predict_clear_section();
	endtask

	// Advance the shadow state by one pixel and queue the hashes it completes.
	task automatic predict_pixel(input pixel_t p);
		logic [63:0] v;
		logic [63:0] ar;
		logic [63:0] ag;
		logic [63:0] ab;
		logic [63:0] factor;
		texture_hashes_t h;
		v = p.inside_req ? 64'((int'(p.red) + int'(p.green) + int'(p.blue)) / 3) : 64'd0;
		pred_running = fnv_step(pred_running, v);
		if (pred_in_lower) begin
			pred_lower = fnv_step(pred_lower, v);
		end
		if (p.inside_req && pred_use_rgb) begin
			pred_red_sum   = add_sat(pred_red_sum, p.red);
			pred_green_sum = add_sat(pred_green_sum, p.green);
			pred_blue_sum  = add_sat(pred_blue_sum, p.blue);
		end
		if (pred_count < COUNT_MAX) begin
			pred_count++;
		end
		if (!p.section_end) begin
			return;
		end

		// Section end: fold any rgb averages, then either open the lower section or report.
		if (pred_use_rgb) begin
			ar = rounded_avg(pred_red_sum, pred_count);
			ag = rounded_avg(pred_green_sum, pred_count);
			ab = rounded_avg(pred_blue_sum, pred_count);
			pred_running = fnv_step(fnv_step(fnv_step(pred_running, ar), ag), ab);
			if (pred_in_lower) begin
				pred_lower = fnv_step(fnv_step(fnv_step(pred_lower, ar), ag), ab);
			end
		end
		if (!pred_in_lower) begin
			if (p.tall) begin
				factor = prime_to(pred_use_rgb ? NUM_SAMPLES + RGB_EXTRA : NUM_SAMPLES);
				pred_upper_held = pred_running * factor;
				pred_lower      = FNV_BASIS * factor;
				pred_in_lower   = 1'b1;
				predict_clear_section();
				return;
			end
			h.combined = pred_running;
			h.upper    = pred_running;
			h.lower    = 64'd0;
		end else begin
			h.combined = pred_running;
			h.upper    = pred_upper_held;
			h.lower    = pred_lower;
		end
		hash_expect_q.insert(hash_expect_q.size(), h);
		predict_clear_texture();
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_MAX) begin
			$display("MISMATCH at cycle %0d: %s", cycles, msg);
		end
	endtask

	// Offer one pixel beat, idling first at random, and predict it once accepted.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid = 1'b0;
			@(negedge clk);
		end
		pix.valid       = 1'b1;
		pix.red         = p.red;
		pix.green       = p.green;
		pix.blue        = p.blue;
		pix.inside_req  = p.inside_req;
		pix.section_end = p.section_end;
		pix.tall        = p.tall;
		@(posedge clk);
		while (!pix.ready) begin
			@(posedge clk);
		end
		predict_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	// A section of random pixels; tall is random except at the end of the section.
	task automatic send_section(input int len, input int inside_pct, input logic tall_at_end);
		pixel_t p;
		for (int i = 0; i < len; i++) begin
			p = px(rand_channel(), rand_channel(), rand_channel(),
				$urandom_range(99) < inside_pct, i == len - 1,
				(i == len - 1) ? tall_at_end : 1'($urandom_range(1)));
			send_pixel(p);
		end
	endtask

	task automatic send_texture(input int upper_len, input int lower_len, input int inside_pct);
		send_section(upper_len, inside_pct, lower_len > 0);
		if (lower_len > 0) begin
			send_section(lower_len, inside_pct, 1'($urandom_range(1)));
		end
	endtask

	// Stop offering and let every queued result and any trailing work drain.
	task automatic wait_idle();
		pix.valid = 1'b0;
		while (hash_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_use_rgb(input logic value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en    = 1'b0;
		pred_use_rgb = value;
	endtask

	// Single-pixel textures at the channel extremes, an outside pixel and a half-rounding pair.
	task automatic test_single_pixels();
		send_pixel(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0));
		send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0));
		send_pixel(px(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0));
		send_pixel(px(8'd1, 8'd1, 8'd0, 1'b1, 1'b0, 1'b0));
		send_pixel(px(8'd0, 8'd2, 8'd255, 1'b1, 1'b1, 1'b0));
		wait_idle();
	endtask

	// Tall texture, with tall also set on the lower section end where it is ignored.
	task automatic test_tall_texture();
		send_pixel(px(8'd200, 8'd10, 8'd30, 1'b1, 1'b0, 1'b1));
		send_pixel(px(8'd7, 8'd8, 8'd9, 1'b0, 1'b1, 1'b1));
		send_pixel(px(8'd100, 8'd100, 8'd100, 1'b1, 1'b0, 1'b0));
		send_pixel(px(8'd255, 8'd0, 8'd128, 1'b1, 1'b1, 1'b1));
		wait_idle();
	endtask

	// use_rgb changed inside a section, off at the upper end, and back on in the lower section.
	task automatic test_rgb_switch();
		send_pixel(px(8'd90, 8'd180, 8'd45, 1'b1, 1'b0, 1'b0));
		send_pixel(px(8'd3, 8'd250, 8'd17, 1'b1, 1'b0, 1'b1));
		wait_idle();
		write_use_rgb(1'b0);
		send_pixel(px(8'd64, 8'd32, 8'd16, 1'b1, 1'b0, 1'b0));
		send_pixel(px(8'd11, 8'd22, 8'd33, 1'b1, 1'b1, 1'b1));
		send_pixel(px(8'd128, 8'd127, 8'd129, 1'b1, 1'b0, 1'b0));
		wait_idle();
		write_use_rgb(1'b1);
		send_pixel(px(8'd40, 8'd50, 8'd60, 1'b1, 1'b0, 1'b0));
		send_pixel(px(8'd255, 8'd254, 8'd253, 1'b1, 1'b1, 1'b0));
		wait_idle();
		write_use_rgb(1'b0);
		send_pixel(px(8'd77, 8'd66, 8'd55, 1'b1, 1'b1, 1'b0));
		wait_idle();
		write_use_rgb(1'b1);
	endtask

	// Sections long enough to saturate both the sample count and the channel sums.
	task automatic test_long_sections();
		for (int i = 0; i < 135; i++) begin
			send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, i == 134, 1'b1));
		end
		send_section(129, 90, 1'b0);
		wait_idle();
	endtask

	// The receiver holds off while short textures keep coming, so the input backs up.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = HOLD_OFF;
		for (int i = 0; i < 16; i++) begin
			send_texture(1, 0, 90);
		end
		wait_idle();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input logic rgb);
		int start;
		int inside_pct;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		write_use_rgb(rgb);
		start = pixels_sent;
		while (pixels_sent - start < PHASE_PIXELS) begin
			inside_pct = ($urandom_range(3) == 0) ? 30 : 90;
			send_texture(rand_section_len(),
				$urandom_range(1) ? rand_section_len() : 0, inside_pct);
		end
		wait_idle();
	endtask

	// Result side: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res.ready = 1'b0;
			hold_cycles--;
		end else begin
			res.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result beat with the oldest expected set of hashes.
	always @(posedge clk) begin : check_results
		texture_hashes_t want;
		if (arst_n && res.valid && res.ready) begin
			if (hash_expect_q.size() == 0) begin
				report_mismatch($sformatf("result beat with no hashes expected, combined %h",
					res.combined_hash));
			end else begin
				want = hash_expect_q.pop_front();
				results_checked++;
				if (res.combined_hash !== want.combined)
					report_mismatch($sformatf("combined_hash %h, expected %h",
						res.combined_hash, want.combined));
				if (res.upper_hash !== want.upper)
					report_mismatch($sformatf("upper_hash %h, expected %h",
						res.upper_hash, want.upper));
				if (res.lower_hash !== want.lower)
					report_mismatch($sformatf("lower_hash %h, expected %h",
						res.lower_hash, want.lower));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped by the watchdog after %0d cycles.", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pix.valid       = 1'b0;
		pix.red         = 8'd0;
		pix.green       = 8'd0;
		pix.blue        = 8'd0;
		pix.inside_req  = 1'b0;
		pix.section_end = 1'b0;
		pix.tall        = 1'b0;
		res.ready       = 1'b0;
		pred_use_rgb    = 1'b1;
		predict_clear_texture();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_pixels();
		test_tall_texture();
		test_rgb_switch();
		test_long_sections();
		test_backpressure();
		test_random_phase(0, 0, 1'b1);
		test_random_phase(83, 0, 1'b0);
		test_random_phase(0, 83, 1'b1);
		test_random_phase(14, 14, 1'b0);

		// Anything still queued here never arrived.
		foreach (hash_expect_q[i]) begin
			report_mismatch($sformatf("expected combined %h never arrived",
				hash_expect_q[i].combined));
		end

		$display("Sent %0d pixels, checked %0d texture results over directed and random phases.",
			pixels_sent, results_checked);
		$display("Covered both use_rgb settings, tall textures, saturation and output back-pressure.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
